FILE: sv/ttv_pkg.sv
package ttv_pkg;

	localparam int POS_WIDTH_DEF = 24;
	localparam int UV_WIDTH_DEF  = 16;
	localparam int OUT_FRAC_DEF  = 14;
	localparam int TAN_WIDTH     = 16;
	localparam int NORM_TOP      = 29;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_ABS,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_MUL,
		OP_ABS,
		OP_NORM,
		OP_SQ,
		OP_SQRT,
		OP_DIV,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] cnt;
		logic [1:0] lane;
	} cmd_t;

	typedef struct packed {
		logic slot_full;
		logic degen;
		logic norm_ok;
	} status_t;

endpackage

FILE: sv/ttv_in_if.sv
interface ttv_in_if import ttv_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int UV_WIDTH  = UV_WIDTH_DEF
) ();
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] pos_x;
	logic signed [POS_WIDTH-1:0] pos_y;
	logic signed [POS_WIDTH-1:0] pos_z;
	logic signed [UV_WIDTH-1:0]  tex_u;
	logic signed [UV_WIDTH-1:0]  tex_v;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

FILE: sv/ttv_out_if.sv
interface ttv_out_if import ttv_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [TAN_WIDTH-1:0] tan_x;
	logic signed [TAN_WIDTH-1:0] tan_y;
	logic signed [TAN_WIDTH-1:0] tan_z;
	logic                        degenerate;

	modport source (output valid, tan_x, tan_y, tan_z, degenerate, input ready);
	modport sink (input valid, tan_x, tan_y, tan_z, degenerate, output ready);
endinterface

FILE: sv/ttv_ctrl.sv
module ttv_ctrl import ttv_pkg::*; #(
	parameter int OUT_FRAC = OUT_FRAC_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);
	// quotient bits per lane
	localparam int QB = OUT_FRAC + 1;

	state_t     st_q, st_d;
	logic [5:0] cnt_q, cnt_d;
	logic [1:0] lane_q, lane_d;
	logic       ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			lane_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			cnt_q  <= cnt_d;
			lane_q <= lane_d;
			ov_q   <= ov_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		cnt_d    = cnt_q;
		lane_d   = lane_q;
		ov_d     = ov_q && !out_ready;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.cnt  = cnt_q;
		cmd.lane = lane_q;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (status.slot_full) st_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.op = OP_DIFF;
				cnt_d  = '0;
				st_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				if (cnt_q == 6'd8) begin
					cnt_d = '0;
					st_d  = ST_ABS;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_ABS: begin
				cmd.op = OP_ABS;
				st_d   = ST_NORM;
			end
			ST_NORM: begin
				if (status.degen) begin
					st_d = ST_OUT;
				end else if (status.norm_ok) begin
					cnt_d = '0;
					st_d  = ST_SQ;
				end else begin
					cmd.op = OP_NORM;
				end
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				if (cnt_q == 6'd3) begin
					cnt_d = '0;
					st_d  = ST_SQRT;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == 6'd31) begin
					cnt_d  = '0;
					lane_d = '0;
					st_d   = ST_DIV;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == 6'(QB)) begin
					cnt_d = '0;
					if (lane_q == 2'd2) st_d = ST_OUT;
					else lane_d = lane_q + 2'd1;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_OUT: begin
				if (!ov_q || out_ready) begin
					cmd.op = OP_OUT;
					ov_d   = 1'b1;
					st_d   = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign out_valid = ov_q;

endmodule

FILE: sv/ttv_dp.sv
module ttv_dp import ttv_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int UV_WIDTH  = UV_WIDTH_DEF,
	parameter int OUT_FRAC  = OUT_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmd_t                        cmd,
	output status_t                     status,
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic signed [POS_WIDTH-1:0] pos_z,
	input  logic signed [UV_WIDTH-1:0]  tex_u,
	input  logic signed [UV_WIDTH-1:0]  tex_v,
	output logic signed [TAN_WIDTH-1:0] tan_x,
	output logic signed [TAN_WIDTH-1:0] tan_y,
	output logic signed [TAN_WIDTH-1:0] tan_z,
	output logic                        degenerate
);
	localparam int EW   = POS_WIDTH + 1;
	localparam int DW   = UV_WIDTH + 1;
	localparam int BW   = (EW > DW) ? EW : DW;
	localparam int PRW  = DW + BW;
	localparam int TW   = PRW + 1;
	localparam int NW   = (TW > 31) ? TW : 31;
	localparam int QB   = OUT_FRAC + 1;
	localparam int NUMW = NORM_TOP + 1 + OUT_FRAC + 1;
	localparam int RW   = 32;

	logic signed [POS_WIDTH-1:0] held_p_q [6];
	logic signed [UV_WIDTH-1:0]  held_uv_q [4];
	logic signed [POS_WIDTH-1:0] cur_p_q [3];
	logic signed [UV_WIDTH-1:0]  cur_uv_q [2];
	logic [1:0]                  slot_q;

	logic signed [EW-1:0]  e1_q [3];
	logic signed [EW-1:0]  e2_q [3];
	logic signed [DW-1:0]  du1_q, dv1_q, du2_q, dv2_q;
	logic signed [PRW-1:0] prod_s1;
	logic signed [PRW-1:0] acc_q;
	logic signed [TW-1:0]  res_q [4];   // det, then tangent x/y/z
	logic [NW-1:0]         mag_q [3];
	logic                  neg_q [3];
	logic                  deg_q;
	logic [59:0]           sq_s1;
	logic [61:0]           ss_q;
	logic [63:0]           sx_q, rt_q, bit_q;
	logic [NUMW-1:0]       nd_q;
	logic [RW:0]           rem_q;
	logic [QB-1:0]         quo_q;
	logic [QB-1:0]         q_q [3];
	logic signed [TAN_WIDTH-1:0] tan_q [3];

	// first held position entry of the current slot
	logic [2:0] pbase;
	assign pbase = slot_q[0] ? 3'd3 : 3'd0;

	// multiplier operand select
	logic signed [DW-1:0] ma;
	logic signed [BW-1:0] mb;
	always_comb begin
		ma = dv1_q;
		mb = BW'(e2_q[2]);
		case (cmd.cnt[2:0])
			3'd0: begin ma = du1_q; mb = BW'(dv2_q); end
			3'd1: begin ma = du2_q; mb = BW'(dv1_q); end
			3'd2: begin ma = dv2_q; mb = BW'(e1_q[0]); end
			3'd3: begin ma = dv1_q; mb = BW'(e2_q[0]); end
			3'd4: begin ma = dv2_q; mb = BW'(e1_q[1]); end
			3'd5: begin ma = dv1_q; mb = BW'(e2_q[1]); end
			3'd6: begin ma = dv2_q; mb = BW'(e1_q[2]); end
			default: begin ma = dv1_q; mb = BW'(e2_q[2]); end
		endcase
	end

	logic [5:0] pj;
	assign pj = cmd.cnt - 6'd1;

	// tangent components with the determinant sign flipped, before the absolute value
	logic signed [TW:0] tv [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tv[i] = res_q[0] < 0 ? -(TW+1)'(res_q[i+1]) : (TW+1)'(res_q[i+1]);
		end
	end

	// normalization window check on the largest magnitude
	logic [NW-1:0] mx01, mx;
	assign mx01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
	assign mx   = (mx01 > mag_q[2]) ? mx01 : mag_q[2];

	logic norm_ok;
	assign norm_ok = ((mx >> (NORM_TOP + 1)) == '0) && mx[NORM_TOP];

	logic [NORM_TOP:0] nm [3];
	always_comb begin
		for (int i = 0; i < 3; i++) nm[i] = mag_q[i][NORM_TOP:0];
	end

	logic [NORM_TOP:0] sq_op;
	always_comb begin
		case (cmd.cnt[1:0])
			2'd0:    sq_op = nm[0];
			2'd1:    sq_op = nm[1];
			default: sq_op = nm[2];
		endcase
	end

	logic [63:0] rb;
	assign rb = rt_q + bit_q;

	// division step
	logic [RW-1:0]   r;
	logic [NORM_TOP:0] dn_op;
	logic [NUMW-1:0] n_new;
	logic [RW:0]     trial;
	logic            ge;
	logic [QB-1:0]   quo_n;
	assign r = rt_q[RW-1:0];
	always_comb begin
		case (cmd.lane)
			2'd0:    dn_op = nm[0];
			2'd1:    dn_op = nm[1];
			default: dn_op = nm[2];
		endcase
	end
	assign n_new = (NUMW'(dn_op) << OUT_FRAC) + NUMW'(r >> 1);
	assign trial = {rem_q[RW-1:0], nd_q[QB-1]};
	assign ge    = trial >= {1'b0, r};
	assign quo_n = {quo_q[QB-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slot_q <= '0;
		else if (cmd.op == OP_LOAD) slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				if (slot_q == 2'd2) begin
					cur_p_q[0]  <= pos_x;
					cur_p_q[1]  <= pos_y;
					cur_p_q[2]  <= pos_z;
					cur_uv_q[0] <= tex_u;
					cur_uv_q[1] <= tex_v;
				end else begin
					held_p_q[pbase]        <= pos_x;
					held_p_q[pbase + 3'd1] <= pos_y;
					held_p_q[pbase + 3'd2] <= pos_z;
					held_uv_q[{slot_q[0], 1'b0}]        <= tex_u;
					held_uv_q[{slot_q[0], 1'b1}]        <= tex_v;
				end
			end
			OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= EW'(held_p_q[3+i]) - EW'(held_p_q[i]);
					e2_q[i] <= EW'(cur_p_q[i]) - EW'(held_p_q[i]);
				end
				du1_q <= DW'(held_uv_q[2]) - DW'(held_uv_q[0]);
				dv1_q <= DW'(held_uv_q[3]) - DW'(held_uv_q[1]);
				du2_q <= DW'(cur_uv_q[0]) - DW'(held_uv_q[0]);
				dv2_q <= DW'(cur_uv_q[1]) - DW'(held_uv_q[1]);
			end
			OP_MUL: begin
				prod_s1 <= PRW'(ma) * PRW'(mb);
				if (cmd.cnt != 6'd0) begin
					if (!pj[0]) acc_q <= prod_s1;
					else res_q[pj[2:1]] <= TW'(acc_q) - TW'(prod_s1);
				end
			end
			OP_ABS: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= tv[i] < 0;
					mag_q[i] <= NW'(tv[i] < 0 ? -tv[i] : tv[i]);
				end
				deg_q <= (res_q[0] == '0) ||
					((res_q[1] == '0) && (res_q[2] == '0) && (res_q[3] == '0));
			end
			OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					if ((mx >> (NORM_TOP + 5)) != '0)      mag_q[i] <= mag_q[i] >> 4;
					else if ((mx >> (NORM_TOP + 1)) != '0) mag_q[i] <= mag_q[i] >> 1;
					else if ((mx >> (NORM_TOP - 4)) == '0) mag_q[i] <= mag_q[i] << 4;
					else if (!mx[NORM_TOP])                mag_q[i] <= mag_q[i] << 1;
				end
			end
			OP_SQ: begin
				sq_s1 <= 60'(sq_op) * 60'(sq_op);
				case (cmd.cnt[1:0])
					2'd1: ss_q <= 62'(sq_s1);
					2'd2: ss_q <= ss_q + 62'(sq_s1);
					2'd3: begin
						sx_q  <= 64'(ss_q + 62'(sq_s1));
						rt_q  <= '0;
						bit_q <= 64'(1) << 62;
					end
					default: ;
				endcase
			end
			OP_SQRT: begin
				if (sx_q >= rb) begin
					sx_q <= sx_q - rb;
					rt_q <= (rt_q >> 1) + bit_q;
				end else begin
					rt_q <= rt_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV: begin
				if (cmd.cnt == 6'd0) begin
					nd_q  <= n_new;
					rem_q <= (RW+1)'(n_new >> QB);
					quo_q <= '0;
				end else begin
					nd_q  <= nd_q << 1;
					rem_q <= ge ? trial - {1'b0, r} : trial;
					quo_q <= quo_n;
					if (cmd.cnt == 6'(QB)) q_q[cmd.lane] <= quo_n;
				end
			end
			OP_OUT: begin
				for (int i = 0; i < 3; i++) begin
					if (deg_q) tan_q[i] <= '0;
					else if (neg_q[i]) tan_q[i] <= TAN_WIDTH'(-32'(q_q[i]));
					else tan_q[i] <= TAN_WIDTH'(32'(q_q[i]));
				end
				degenerate <= deg_q;
			end
			default: ;
		endcase
	end

	assign tan_x = tan_q[0];
	assign tan_y = tan_q[1];
	assign tan_z = tan_q[2];

	assign status.slot_full = (slot_q == 2'd2);
	assign status.degen     = deg_q;
	assign status.norm_ok   = norm_ok;

endmodule

FILE: sv/triangle_tangent_vector_core.sv
// channel | dir | payload                                  | notes
// vin     | in  | pos_x/y/z Q12.12, tex_u/v Q4.12          | one vertex per request
// vout    | out | tan_x/y/z Q2.14, degenerate              | one result per 3rd vertex
//
// Vertices 0 and 1 of a triangle are only stored. Vertex 2 starts a run of
// diff, multiply, abs, normalize, square, root, per-lane divide and output
// steps; normalize is one window check plus the shift-by-4/shift-by-1 steps.
// The root is bit-per-cycle and the divider is restoring.
// Degenerate triangles skip straight from normalize to output.
// arst_n clears the FSM, vertex slot and output valid; data registers keep junk.
// A stalled result holds in the output register; next vertices are still taken
// while it waits, and a new result waits until the old one leaves.
module triangle_tangent_vector_core import ttv_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int UV_WIDTH  = UV_WIDTH_DEF,
	parameter int OUT_FRAC  = OUT_FRAC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ttv_in_if.sink     vin,
	ttv_out_if.source  vout
);
	cmd_t    cmd;
	status_t status;

	// sequencer: one triangle at a time
	ttv_ctrl #(
		.OUT_FRAC (OUT_FRAC)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vin.valid),
		.in_ready  (vin.ready),
		.out_valid (vout.valid),
		.out_ready (vout.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic: vertex store, shared multiplier, normalizer, root, divider
	ttv_dp #(
		.POS_WIDTH (POS_WIDTH),
		.UV_WIDTH  (UV_WIDTH),
		.OUT_FRAC  (OUT_FRAC)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.pos_x      (POS_WIDTH'(vin.pos_x)),
		.pos_y      (POS_WIDTH'(vin.pos_y)),
		.pos_z      (POS_WIDTH'(vin.pos_z)),
		.tex_u      (UV_WIDTH'(vin.tex_u)),
		.tex_v      (UV_WIDTH'(vin.tex_v)),
		.tan_x      (vout.tan_x),
		.tan_y      (vout.tan_y),
		.tan_z      (vout.tan_z),
		.degenerate (vout.degenerate)
	);

endmodule
